// ===== design/rau_pkg.sv =====
// ----------------------------------------------------------------------------
// rau_pkg
// Shared types, command codes and controller interface for the rational ALU.
// ----------------------------------------------------------------------------
`default_nettype none
package rau_pkg;

  localparam int unsigned OperandWidth = 32;
  localparam int unsigned DenWidth     = OperandWidth - 1;
  localparam int unsigned ResWidth     = 64;
  localparam int unsigned CntWidth     = 6;

  localparam logic [2:0] CmdAdd  = 3'd0;
  localparam logic [2:0] CmdSub  = 3'd1;
  localparam logic [2:0] CmdMul  = 3'd2;
  localparam logic [2:0] CmdDiv  = 3'd3;
  localparam logic [2:0] CmdCmp  = 3'd4;
  localparam logic [2:0] CmdRed  = 3'd5;
  localparam logic [2:0] CmdFlip = 3'd6;

  typedef struct packed {
    logic [2:0]                 command;
    logic signed [OperandWidth-1:0] a_num;
    logic [DenWidth-1:0]        a_den;
    logic signed [OperandWidth-1:0] b_num;
    logic [DenWidth-1:0]        b_den;
  } rau_in_t;

  typedef struct packed {
    logic signed [ResWidth-1:0] res_num;
    logic signed [ResWidth-1:0] res_den;
    logic                       is_less;
    logic                       is_greater;
    logic                       is_equal;
    logic                       error;
  } rau_out_t;

  // controller -> datapath
  typedef struct packed {
    logic load;     // capture operands
    logic mul;      // compute products
    logic fin;      // form result for non-reduce commands and trivial reduce
    logic gcd_step; // one binary gcd step
    logic div_init; // start both quotient divisions
    logic div_step; // one restoring division bit
    logic red_fin;  // form reduce result
  } rau_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_reduce;
    logic red_trivial;
    logic gcd_done;
  } rau_sts_t;

endpackage
`default_nettype wire

// ===== design/rau_datapath.sv =====
// ----------------------------------------------------------------------------
// rau_datapath
// Operand registers, products, binary gcd and two restoring dividers sharing one divisor.
// ----------------------------------------------------------------------------
`default_nettype none
module rau_datapath (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  rau_pkg::rau_in_t    in_i,
  input  rau_pkg::rau_cmd_t   cmd_i,
  output rau_pkg::rau_sts_t   sts_o,
  output rau_pkg::rau_out_t   res_o
);
  import rau_pkg::*;

  localparam int unsigned W = OperandWidth;

  logic [2:0]          cmd_q;
  logic signed [W-1:0] an_q, bn_q;
  logic [W-2:0]        ad_q, bd_q;
  logic signed [63:0]  p0_q, p1_q, p2_q, p3_q;
  logic [W-1:0]        gx_q, gy_q, gx_d, gy_d;
  logic [CntWidth-1:0] gk_q, gk_d;
  logic [W-1:0]        dvs_q;
  logic [W-1:0]        qn_q, qd_q, rn_q, rd_q;
  logic [W-1:0]        mag;
  rau_out_t            res_q, res_d;

  assign mag = an_q[W-1] ? (W)'(-an_q) : an_q;

  assign sts_o.is_reduce   = (cmd_q == CmdRed);
  assign sts_o.red_trivial = (an_q == '0) || (ad_q == '0);
  assign sts_o.gcd_done    = (gy_q == '0);
  assign res_o = res_q;

  // remainder shift-subtract helpers
  logic [W:0] rn_sh, rd_sh;
  assign rn_sh = {rn_q, qn_q[W-1]};
  assign rd_sh = {rd_q, qd_q[W-1]};

  always_comb begin
    gx_d = gx_q;
    gy_d = gy_q;
    gk_d = gk_q;
    if (gx_q == '0) begin
      gx_d = gy_q;
      gy_d = '0;
    end else if (gx_q[0] == 1'b0 && gy_q[0] == 1'b0) begin
      gx_d = gx_q >> 1;
      gy_d = gy_q >> 1;
      gk_d = gk_q + 1'b1;
    end else if (gx_q[0] == 1'b0) begin
      gx_d = gx_q >> 1;
    end else if (gy_q[0] == 1'b0) begin
      gy_d = gy_q >> 1;
    end else if (gx_q >= gy_q) begin
      gx_d = (gx_q - gy_q) >> 1;
    end else begin
      gy_d = (gy_q - gx_q) >> 1;
    end
  end

  always_comb begin
    res_d = '0;
    if (cmd_i.red_fin) begin
      res_d.res_num = an_q[W-1] ? -64'(qn_q) : 64'(qn_q);
      res_d.res_den = 64'(qd_q);
    end else begin
      case (cmd_q)
        CmdAdd: begin
          res_d.res_num = p0_q + p1_q;
          res_d.res_den = p3_q;
        end
        CmdSub: begin
          res_d.res_num = p0_q - p1_q;
          res_d.res_den = p3_q;
        end
        CmdMul: begin
          res_d.res_num = p2_q;
          res_d.res_den = p3_q;
        end
        CmdDiv: begin
          if (bn_q == '0) begin
            res_d.res_num = 64'(bn_q);
            res_d.res_den = 64'({1'b0, bd_q});
            res_d.error   = 1'b1;
          end else begin
            res_d.res_num = p0_q;
            res_d.res_den = p3_q;
          end
        end
        CmdCmp: begin
          res_d.is_less    = p0_q < p1_q;
          res_d.is_greater = p0_q > p1_q;
          res_d.is_equal   = (an_q == bn_q) && (ad_q == bd_q);
        end
        CmdRed: begin
          res_d.res_num = 64'(an_q);
          res_d.res_den = 64'({1'b0, ad_q});
        end
        CmdFlip: begin
          if (an_q == '0) begin
            res_d.res_num = '0;
            res_d.res_den = 64'({1'b0, ad_q});
            res_d.error   = 1'b1;
          end else begin
            res_d.res_num = 64'({1'b0, ad_q});
            res_d.res_den = 64'(an_q);
          end
        end
        default: res_d.error = 1'b1;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_q <= '0;
      an_q  <= '0;
      ad_q  <= '0;
      bn_q  <= '0;
      bd_q  <= '0;
      p0_q  <= '0;
      p1_q  <= '0;
      p2_q  <= '0;
      p3_q  <= '0;
      gx_q  <= '0;
      gy_q  <= '0;
      gk_q  <= '0;
      dvs_q <= '0;
      qn_q  <= '0;
      qd_q  <= '0;
      rn_q  <= '0;
      rd_q  <= '0;
      res_q <= '0;
    end else begin
      if (cmd_i.load) begin
        cmd_q <= in_i.command;
        an_q  <= in_i.a_num;
        ad_q  <= in_i.a_den;
        bn_q  <= in_i.b_num;
        bd_q  <= in_i.b_den;
      end
      if (cmd_i.mul) begin
        p0_q <= 64'(an_q) * 64'(signed'({1'b0, bd_q}));
        p1_q <= 64'(bn_q) * 64'(signed'({1'b0, ad_q}));
        p2_q <= 64'(an_q) * 64'(bn_q);
        p3_q <= (cmd_q == CmdDiv) ? 64'(signed'({1'b0, ad_q})) * 64'(bn_q)
                                  : 64'(signed'({1'b0, ad_q})) * 64'(signed'({1'b0, bd_q}));
        gx_q <= mag;
        gy_q <= W'(ad_q);
        gk_q <= '0;
      end
      if (cmd_i.gcd_step) begin
        gx_q <= gx_d;
        gy_q <= gy_d;
        gk_q <= gk_d;
      end
      if (cmd_i.div_init) begin
        dvs_q <= gx_q << gk_q;
        qn_q  <= mag;
        qd_q  <= W'(ad_q);
        rn_q  <= '0;
        rd_q  <= '0;
      end
      if (cmd_i.div_step) begin
        if (rn_sh >= {1'b0, dvs_q}) begin
          rn_q <= W'(rn_sh - {1'b0, dvs_q});
          qn_q <= {qn_q[W-2:0], 1'b1};
        end else begin
          rn_q <= rn_sh[W-1:0];
          qn_q <= {qn_q[W-2:0], 1'b0};
        end
        if (rd_sh >= {1'b0, dvs_q}) begin
          rd_q <= W'(rd_sh - {1'b0, dvs_q});
          qd_q <= {qd_q[W-2:0], 1'b1};
        end else begin
          rd_q <= rd_sh[W-1:0];
          qd_q <= {qd_q[W-2:0], 1'b0};
        end
      end
      if (cmd_i.fin || cmd_i.red_fin) begin
        res_q <= res_d;
      end
    end
  end
endmodule
`default_nettype wire

// ===== design/rau_ctrl.sv =====
// ----------------------------------------------------------------------------
// rau_ctrl
// Sequencer: operand load, products, gcd loop, division loop, result hold.
// ----------------------------------------------------------------------------
`default_nettype none
module rau_ctrl (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_stall_o,
  output logic                out_valid_o,
  input  wire                 out_stall_i,
  input  rau_pkg::rau_sts_t   sts_i,
  output rau_pkg::rau_cmd_t   cmd_o
);
  import rau_pkg::*;

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StMul  = 3'd1;
  localparam logic [2:0] StSel  = 3'd2;
  localparam logic [2:0] StGcd  = 3'd3;
  localparam logic [2:0] StDiv  = 3'd4;
  localparam logic [2:0] StOut  = 3'd5;

  logic [2:0]          state_q, state_d;
  logic [CntWidth-1:0] cnt_q, cnt_d;

  assign in_stall_o  = (state_q != StIdle);
  assign out_valid_o = (state_q == StOut);

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = StMul;
        end
      end
      StMul: begin
        cmd_o.mul = 1'b1;
        state_d   = StSel;
      end
      StSel: begin
        if (sts_i.is_reduce && !sts_i.red_trivial) begin
          state_d = StGcd;
        end else begin
          cmd_o.fin = 1'b1;
          state_d   = StOut;
        end
      end
      StGcd: begin
        if (sts_i.gcd_done) begin
          cmd_o.div_init = 1'b1;
          cnt_d          = '0;
          state_d        = StDiv;
        end else begin
          cmd_o.gcd_step = 1'b1;
        end
      end
      StDiv: begin
        if (cnt_q == CntWidth'(OperandWidth)) begin
          cmd_o.red_fin = 1'b1;
          state_d       = StOut;
        end else begin
          cmd_o.div_step = 1'b1;
          cnt_d          = cnt_q + 1'b1;
        end
      end
      StOut: begin
        if (!out_stall_i) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end
endmodule
`default_nettype wire

// ===== design/rational_arithmetic_unit_top.sv =====
// ----------------------------------------------------------------------------
// rational_arithmetic_unit_top
// Fraction ALU: add, subtract, multiply, divide, compare, reduce, flip.
// ----------------------------------------------------------------------------
// channel | valid       | stall       | payload
// in      | in_valid_i  | in_stall_o  | in_data_i  (rau_in_t)
// out     | out_valid_o | out_stall_i | out_data_o (rau_out_t)
// One item at a time. Non-reduce commands: operand load, products, then result.
// Reduce: operand load, products, binary gcd steps, division start, restoring
// division steps, then result; a zero numerator or denominator skips to result.
// The result holds while out_stall_i is high; next item taken after it leaves.
// Reset clears the sequencer and all datapath registers.
// ----------------------------------------------------------------------------
`default_nettype none
module rational_arithmetic_unit_top (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                in_valid_i,
  output logic               in_stall_o,
  input  rau_pkg::rau_in_t   in_data_i,
  output logic               out_valid_o,
  input  wire                out_stall_i,
  output rau_pkg::rau_out_t  out_data_o
);
  import rau_pkg::*;

  rau_cmd_t cmd;
  rau_sts_t sts;

  rau_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
    .sts_i(sts), .cmd_o(cmd)
  );

  rau_datapath u_dp (
    .clk_i, .rst_ni, .in_i(in_data_i), .cmd_i(cmd), .sts_o(sts), .res_o(out_data_o)
  );
endmodule
`default_nettype wire
